@@ rtl/mdt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mdt_pkg;

    // event codes; code 7 is unused and changes nothing
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_OPEN   = 3'd1;
    localparam logic [2:0] OP_CLOSE  = 3'd2;
    localparam logic [2:0] OP_SET    = 3'd3;
    localparam logic [2:0] OP_START  = 3'd4;
    localparam logic [2:0] OP_STOP   = 3'd5;
    localparam logic [2:0] OP_CLEAR  = 3'd6;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    localparam int ADD_TIME = 30;

    typedef enum logic [2:0] {
        MODE_CLOSED_EMPTY = 3'd0,
        MODE_OPEN_TIMED   = 3'd1,
        MODE_OPEN_EMPTY   = 3'd2,
        MODE_CLOSED_IDLE  = 3'd3,
        MODE_HEATING      = 3'd4
    } t_mode;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] time_value;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  mode_code;
        logic        magnetron_on;
        logic        door_is_open;
        logic [15:0] time_shown;
    } t_out_word;

endpackage

`default_nettype wire

@@ rtl/microwave_door_timer_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake           word
// input     in         i_valid / o_stall   i_data  (op, time_value)
// result    out        o_valid / i_stall   o_data  (mode, flags, time_shown)
//
// One word per cycle sustained while the result is not stalled; each event's
// result is formed by the next-state logic from the input register and is
// registered into the result register.
// Reset is synchronous, active low, and returns to closed with no time.
// A stalled result holds; one more word is taken into the input register
// meanwhile, then o_stall rises until the result is taken.

module microwave_door_timer_controller #(
    parameter int TIME_WIDTH = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    input  wire mdt_pkg::t_in_word i_data,
    output logic               o_valid,
    input  wire                i_stall,
    output mdt_pkg::t_out_word o_data
);
    import mdt_pkg::*;

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;
    t_out_word w_result;
    logic      w_adv;
    logic      w_fire;

    assign w_adv   = !r_out_valid || !i_stall;
    assign w_fire  = r_in_valid && w_adv;
    assign o_stall = r_in_valid && !w_adv;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_word;

    mdt_core #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_word  (r_in_word),
        .o_result(w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_in_word <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
        if (w_fire) begin
            r_out_word <= w_result;
        end
    end

    a_magnetron: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.magnetron_on == (o_data.mode_code == MODE_HEATING))
        else $error("magnetron flag does not match mode");

    a_no_time_hidden: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.mode_code == MODE_CLOSED_EMPTY
                    || o_data.mode_code == MODE_OPEN_EMPTY)
        |-> o_data.time_shown == 16'd0)
        else $error("time shown in a no-time mode");

    a_door_heat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_data.door_is_open && o_data.magnetron_on))
        else $error("heating with door open");

    a_pending_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> r_in_valid)
        else $error("held word lost");

endmodule

`default_nettype wire

@@ rtl/mdt_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mdt_core #(
    parameter int TIME_WIDTH = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_fire,
    input  wire mdt_pkg::t_in_word i_word,
    output mdt_pkg::t_out_word o_result
);
    import mdt_pkg::*;

    t_mode                 r_mode;
    t_mode                 n_mode;
    logic [TIME_WIDTH-1:0] r_rem;
    logic [TIME_WIDTH-1:0] n_rem;
    logic [TIME_WIDTH:0]   w_sum;
    logic [31:0]           w_tv32;
    logic [31:0]           w_rem32;
    logic                  w_shown;

    always_comb begin
        n_mode = r_mode;
        n_rem  = r_rem;
        w_sum  = {1'b0, r_rem} + (TIME_WIDTH+1)'(ADD_TIME);
        w_tv32 = {16'd0, i_word.time_value};
        case (i_word.op)
            OP_TICK: begin
                if (r_mode == MODE_HEATING) begin
                    if (r_rem != '0) n_rem = r_rem - 1'b1;
                    if (r_rem <= TIME_WIDTH'(1)) n_mode = MODE_CLOSED_IDLE;
                end
            end
            OP_OPEN: begin
                if (r_mode == MODE_CLOSED_EMPTY) begin
                    n_mode = MODE_OPEN_EMPTY;
                end else if (r_mode == MODE_CLOSED_IDLE || r_mode == MODE_HEATING) begin
                    n_mode = MODE_OPEN_TIMED;
                end
            end
            OP_CLOSE: begin
                if (r_mode == MODE_OPEN_EMPTY) begin
                    n_mode = MODE_CLOSED_EMPTY;
                end else if (r_mode == MODE_OPEN_TIMED) begin
                    n_mode = MODE_CLOSED_IDLE;
                end
            end
            OP_SET: begin
                if (r_mode == MODE_OPEN_EMPTY || r_mode == MODE_OPEN_TIMED) begin
                    n_mode = MODE_OPEN_TIMED;
                    n_rem  = w_tv32[TIME_WIDTH-1:0];
                end else if (r_mode == MODE_CLOSED_EMPTY || r_mode == MODE_CLOSED_IDLE) begin
                    n_mode = MODE_CLOSED_IDLE;
                    n_rem  = w_tv32[TIME_WIDTH-1:0];
                end
            end
            OP_START: begin
                if (r_mode == MODE_CLOSED_EMPTY) begin
                    n_mode = MODE_HEATING;
                    n_rem  = TIME_WIDTH'(ADD_TIME);
                end else if (r_mode == MODE_CLOSED_IDLE) begin
                    n_mode = MODE_HEATING;
                end else if (r_mode == MODE_HEATING) begin
                    // saturate on carry out
                    n_rem = w_sum[TIME_WIDTH] ? '1 : w_sum[TIME_WIDTH-1:0];
                end
            end
            OP_STOP: begin
                if (r_mode == MODE_OPEN_TIMED) begin
                    n_mode = MODE_OPEN_EMPTY;
                end else if (r_mode == MODE_CLOSED_IDLE) begin
                    n_mode = MODE_CLOSED_EMPTY;
                end else if (r_mode == MODE_HEATING) begin
                    n_mode = MODE_CLOSED_IDLE;
                end
            end
            OP_CLEAR: begin
                n_mode = MODE_CLOSED_EMPTY;
                n_rem  = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_rem32                   = '0;
        w_rem32[TIME_WIDTH-1:0]   = n_rem;
        w_shown = (n_mode == MODE_OPEN_TIMED) || (n_mode == MODE_CLOSED_IDLE)
                  || (n_mode == MODE_HEATING);
        o_result.mode_code    = n_mode;
        o_result.magnetron_on = (n_mode == MODE_HEATING);
        o_result.door_is_open = (n_mode == MODE_OPEN_TIMED) || (n_mode == MODE_OPEN_EMPTY);
        o_result.time_shown   = w_shown ? w_rem32[15:0] : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_CLOSED_EMPTY;
            r_rem  <= '0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_rem  <= n_rem;
        end
    end

    // state only moves when a word is processed
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_rem) && $stable(r_mode))
        else $error("state changed without a word");

    // quick start from empty loads the default time and heats
    a_start_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_word.op == OP_START && r_mode == MODE_CLOSED_EMPTY
        |=> r_mode == MODE_HEATING && r_rem == TIME_WIDTH'(ADD_TIME))
        else $error("start from empty did not load default time");

    a_mode_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode <= MODE_HEATING)
        else $error("mode register holds an unused code");

endmodule

`default_nettype wire
